// ===== rtl/rtz_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotozoom texel address package
// Shared widths, register codes and the configuration bundle.
// ----------------------------------------------------------------------------
package rtz_pkg;

  localparam int ROW_W    = 7;
  localparam int COL_W    = 9;
  localparam int ADDR_W   = 16;
  localparam int CFG_W    = 16;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;
  localparam int ACC_W    = 24;
  localparam int ASPECT   = 307;
  localparam int STEP_SHL = 6;

  typedef enum logic [1:0] {
    REG_START_X = 2'd0,
    REG_START_Y = 2'd1,
    REG_STEP_X  = 2'd2,
    REG_STEP_Y  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] start_x;
    logic signed [CFG_W-1:0] start_y;
    logic signed [CFG_W-1:0] step_x;
    logic signed [CFG_W-1:0] step_y;
  } cfg_t;

endpackage

// ===== rtl/rtz_addr_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotozoom address pipeline
// Four register stages: orientation and clamping, step products, row
// products with column packing, and the final packed sum.
// ----------------------------------------------------------------------------
module rtz_addr_pipe
  import rtz_pkg::*;
#(
  parameter int ROWS  = 100,
  parameter int STEPS = 160
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,   // row[6:0], column[15:7]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,   // texel_address[15:0]
  output logic [0:0]        m_tuser    // use_rotated_texture[0]
);

  localparam int RW = $clog2(ROWS + 1);
  localparam int KW = $clog2(STEPS + 1);

  logic en;
  logic v1, v2, v3;

  // Stage 1 logic
  logic [ROW_W-1:0]        row;
  logic [COL_W-1:0]        column;
  logic [8:0]              row9, half9, r_full, k_full;
  logic [CFG_W:0]          ext_x, ext_y, mag_x, mag_y;
  logic                    rot_next;
  logic signed [ACC_W-1:0] xa24, ya24, xadd_next, yadd_next;
  logic [7:0]              xpos_next, ypos_next;

  logic [RW-1:0]           s1_r;
  logic [KW-1:0]           s1_k;
  logic signed [ACC_W-1:0] s1_xadd, s1_yadd;
  logic [7:0]              s1_xpos, s1_ypos;
  logic                    s1_rot;

  // Stage 2 logic
  logic signed [32:0]      xs_prod, ys_prod;
  logic signed [ACC_W-1:0] kx_next, ky_next;

  logic [RW-1:0]           s2_r;
  logic signed [ACC_W-1:0] s2_xs, s2_ys, s2_kx, s2_ky;
  logic [7:0]              s2_xpos, s2_ypos;
  logic                    s2_rot;

  // Stage 3 logic
  logic signed [ACC_W-1:0] rx_prod, ry_prod, neg_kx;

  logic [7:0]              s3_rx, s3_ry, s3_xpos, s3_ypos;
  logic [ADDR_W-1:0]       s3_colo;
  logic                    s3_rot;

  // Stage 4 logic
  logic [ADDR_W-1:0]       rowo;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign row    = s_tdata[ROW_W-1:0];
  assign column = s_tdata[ROW_W+COL_W-1:ROW_W];

  always_comb begin
    row9   = {2'b00, row};
    half9  = {1'b0, column[COL_W-1:1]};
    r_full = (row9 >= 9'(ROWS)) ? 9'(ROWS) : row9 + 9'd1;
    k_full = (half9 >= 9'(STEPS)) ? 9'(STEPS) : half9 + 9'd1;

    ext_x    = {cfg.step_x[CFG_W-1], cfg.step_x};
    ext_y    = {cfg.step_y[CFG_W-1], cfg.step_y};
    mag_x    = cfg.step_x[CFG_W-1] ? (17'd0 - ext_x) : ext_x;
    mag_y    = cfg.step_y[CFG_W-1] ? (17'd0 - ext_y) : ext_y;
    rot_next = mag_x > mag_y;

    xa24 = {{2{cfg.step_x[CFG_W-1]}}, cfg.step_x, {STEP_SHL{1'b0}}};
    ya24 = {{2{cfg.step_y[CFG_W-1]}}, cfg.step_y, {STEP_SHL{1'b0}}};
    xadd_next = rot_next ? (24'sd0 - ya24) : xa24;
    yadd_next = rot_next ? xa24 : ya24;
    xpos_next = rot_next ? (8'd0 - cfg.start_y[7:0]) : cfg.start_x[7:0];
    ypos_next = rot_next ? cfg.start_x[7:0] : cfg.start_y[7:0];
  end

  always_comb begin
    xs_prod = 33'(s1_xadd) * 33'(ASPECT);
    ys_prod = 33'(s1_yadd) * 33'(ASPECT);
    kx_next = 24'(s1_xadd * $signed({1'b0, s1_k}));
    ky_next = 24'(s1_yadd * $signed({1'b0, s1_k}));
  end

  always_comb begin
    rx_prod = 24'(s2_xs * $signed({1'b0, s2_r}));
    ry_prod = 24'(s2_ys * $signed({1'b0, s2_r}));
    neg_kx  = 24'sd0 - s2_kx;
  end

  assign rowo = {s3_ypos + s3_ry, s3_xpos + s3_rx};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v1       <= s_tvalid;
      v2       <= v1;
      v3       <= v2;
      m_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r    <= r_full[RW-1:0];
      s1_k    <= k_full[KW-1:0];
      s1_xadd <= xadd_next;
      s1_yadd <= yadd_next;
      s1_xpos <= xpos_next;
      s1_ypos <= ypos_next;
      s1_rot  <= rot_next;

      s2_r    <= s1_r;
      s2_xs   <= xs_prod[31:8];
      s2_ys   <= ys_prod[31:8];
      s2_kx   <= kx_next;
      s2_ky   <= ky_next;
      s2_xpos <= s1_xpos;
      s2_ypos <= s1_ypos;
      s2_rot  <= s1_rot;

      s3_rx   <= rx_prod[23:16];
      s3_ry   <= ry_prod[23:16];
      s3_xpos <= s2_xpos;
      s3_ypos <= s2_ypos;
      s3_colo <= {neg_kx[23:16], s2_ky[23:16]};
      s3_rot  <= s2_rot;

      m_tdata    <= rowo + s3_colo;
      m_tuser[0] <= s3_rot;
    end
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 s_tready ##1 s_tready ##1 s_tready |=> m_tvalid)
    else $error("accepted beat did not reach the output after four free cycles");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !s_tready |=> $stable({v1, v2, v3}))
    else $error("pipeline valid bits moved during a stall");

  a_row_clamp: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (s1_r != '0) && ({{(9-RW){1'b0}}, s1_r} <= 9'(ROWS)))
    else $error("row step count out of range");

  a_col_clamp: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (s1_k != '0) && ({{(9-KW){1'b0}}, s1_k} <= 9'(STEPS)))
    else $error("column step count out of range");
`endif

endmodule

// ===== rtl/rotozoom_texel_address_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotozoom texel address unit
// Configuration registers and the texel address pipeline.
// ----------------------------------------------------------------------------
// The unit takes one pixel beat per clock while the output is not stalled and
// returns its texel address through the four register stages of the
// pipeline, two of which hold the multipliers for the step and row products.
// When the output beat is not taken the whole pipeline holds, so the input
// side stalls in the same cycle. There is no start-up sweep after reset.
module rotozoom_texel_address_unit
  import rtz_pkg::*;
#(
  parameter int ROWS  = 100,
  parameter int STEPS = 160
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,   // row[6:0], column[15:7]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,   // texel_address[15:0]
  output logic [0:0]        m_tuser    // use_rotated_texture[0]
);

  cfg_t     cfg;
  reg_idx_t reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_START_X: begin
          cfg.start_x <= pwdata[CFG_W-1:0];
        end
        REG_START_Y: begin
          cfg.start_y <= pwdata[CFG_W-1:0];
        end
        REG_STEP_X: begin
          cfg.step_x <= pwdata[CFG_W-1:0];
        end
        REG_STEP_Y: begin
          cfg.step_y <= pwdata[CFG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_START_X: prdata = {16'd0, cfg.start_x};
      REG_START_Y: prdata = {16'd0, cfg.start_y};
      REG_STEP_X:  prdata = {16'd0, cfg.step_x};
      REG_STEP_Y:  prdata = {16'd0, cfg.step_y};
      default:     prdata = '0;
    endcase
  end

  rtz_addr_pipe #(
    .ROWS  (ROWS),
    .STEPS (STEPS)
  ) u_pipe (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
